@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/psk8_pkg.sv @@
// types, constants and constellation table of the 8psk slicer and error counter
package psk8_pkg;

    // one input beat
    typedef struct packed {
        logic               kind;
        logic signed [15:0] rx_i;
        logic signed [15:0] rx_q;
    } t_in_beat;

    // one result beat
    typedef struct packed {
        logic [2:0]  decided_symbol;
        logic [2:0]  reference_symbol;
        logic [1:0]  symbol_bit_errors;
        logic [31:0] total_bit_errors;
        logic [31:0] total_bits;
    } t_out_beat;

    // classified item handed from front to back
    typedef struct packed {
        logic               restart;
        logic [2:0]         ref_symbol;
        logic signed [15:0] rx_i;
        logic signed [15:0] rx_q;
    } t_task;

    localparam int PRBS_WIDTH      = 31;
    localparam logic [PRBS_WIDTH-1:0] PRBS_RESET = 31'h2AAA_AAAA;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int BITS_PER_SYMBOL = 3;
    localparam int NUM_POINTS      = 8;

    // input kind codes
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // coordinate codes of the constellation table
    typedef logic signed [2:0] t_code;
    localparam t_code CODE_POS_ONE  = 3'sd2;
    localparam t_code CODE_POS_DIAG = 3'sd1;
    localparam t_code CODE_ZERO     = 3'sd0;
    localparam t_code CODE_NEG_DIAG = -3'sd1;
    localparam t_code CODE_NEG_ONE  = -3'sd2;

    // gray-coded point order
    localparam t_code PT_I [NUM_POINTS] = '{
        CODE_POS_ONE, CODE_POS_DIAG, CODE_NEG_DIAG, CODE_ZERO,
        CODE_POS_DIAG, CODE_ZERO, CODE_NEG_ONE, CODE_NEG_DIAG
    };
    localparam t_code PT_Q [NUM_POINTS] = '{
        CODE_ZERO, CODE_POS_DIAG, CODE_POS_DIAG, CODE_POS_ONE,
        CODE_NEG_DIAG, CODE_NEG_ONE, CODE_ZERO, CODE_NEG_DIAG
    };

endpackage

@@ hw/rtl/psk8_front.sv @@
// front end: seed register, prbs reference generation, item classification
module psk8_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psk8_pkg::PRBS_WIDTH-1:0]     i_cfg_data,
    input  logic                                i_push,
    input  psk8_pkg::t_in_beat                  i_data,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output psk8_pkg::t_task                     o_task
);

    logic [psk8_pkg::PRBS_WIDTH-1:0] r_seed;
    logic [psk8_pkg::PRBS_WIDTH-1:0] r_prbs;
    logic [psk8_pkg::PRBS_WIDTH-1:0] n_prbs;
    logic [2:0]                      w_ref;
    logic                            w_accept;
    logic                            w_restart;

    // three shifts, first bit out lands in the msb
    function automatic logic [psk8_pkg::PRBS_WIDTH+2:0] prbs_step3(
        input logic [psk8_pkg::PRBS_WIDTH-1:0] st
    );
        logic [psk8_pkg::PRBS_WIDTH-1:0] s;
        logic [2:0]                      o;
        s = st;
        o = '0;
        for (int k = 0; k < 3; k++) begin
            o[2-k] = s[30];
            s      = {s[29:0], s[30] ^ s[2]};
        end
        return {o, s};
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_push && !i_q_full;
    assign w_restart   = (i_data.kind == psk8_pkg::KIND_RESTART);
    assign {w_ref, n_prbs} = prbs_step3(r_prbs);

    // classified item into the queue
    assign o_q_push          = w_accept;
    assign o_task.restart    = w_restart;
    assign o_task.ref_symbol = w_restart ? 3'd0 : w_ref;
    assign o_task.rx_i       = i_data.rx_i;
    assign o_task.rx_q       = i_data.rx_q;

    // seed and prbs state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= psk8_pkg::PRBS_RESET;
            r_prbs <= psk8_pkg::PRBS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (w_accept) begin
                r_prbs <= w_restart ? r_seed : n_prbs;
            end
        end
    end

endmodule

@@ hw/rtl/psk8_queue.sv @@
// short register queue between front and back
module psk8_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psk8_pkg::t_task i_task,
    output logic            o_full,
    input  logic            i_pop,
    output psk8_pkg::t_task o_task,
    output logic            o_empty
);

    psk8_pkg::t_task                   r_mem [psk8_pkg::QUEUE_DEPTH];
    logic [psk8_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [psk8_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [psk8_pkg::QUEUE_PTR_W:0]    r_count;
    logic                              w_wr;
    logic                              w_rd;

    assign o_full  = (r_count == (psk8_pkg::QUEUE_PTR_W+1)'(psk8_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_task  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/psk8_back.sv @@
// back end: distance pipeline, min search, error compare, saturating counters
module psk8_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  psk8_pkg::t_task     i_task,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output psk8_pkg::t_out_beat o_data
);

    localparam int NP   = psk8_pkg::NUM_POINTS;
    localparam int DW   = SAMPLE_WIDTH + 1;
    localparam int QW   = 2 * SAMPLE_WIDTH;
    localparam int SUMW = 2 * SAMPLE_WIDTH + 1;
    localparam logic [63:0] ONE64  = 64'd1 << (SAMPLE_WIDTH - 3);
    localparam logic [63:0] DIAG64 = ((ONE64 * 64'd3037000500) + 64'd2147483648) >> 32;
    localparam logic signed [DW-1:0] PT_ONE  = DW'(ONE64);
    localparam logic signed [DW-1:0] PT_DIAG = DW'(DIAG64);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    function automatic logic signed [DW-1:0] coord(input psk8_pkg::t_code code);
        logic signed [DW-1:0] v;
        unique case (code)
            psk8_pkg::CODE_POS_ONE:  v = PT_ONE;
            psk8_pkg::CODE_POS_DIAG: v = PT_DIAG;
            psk8_pkg::CODE_NEG_DIAG: v = -PT_DIAG;
            psk8_pkg::CODE_NEG_ONE:  v = -PT_ONE;
            default:                 v = '0;
        endcase
        return v;
    endfunction

    logic                        w_adv;
    logic signed [SAMPLE_WIDTH-1:0] w_ri;
    logic signed [SAMPLE_WIDTH-1:0] w_rq;

    // stage 1: differences
    logic                        r_s1_valid;
    logic                        r_s1_restart;
    logic [2:0]                  r_s1_ref;
    logic signed [DW-1:0]        r_s1_di [NP];
    logic signed [DW-1:0]        r_s1_dq [NP];
    // stage 2: squares
    logic                        r_s2_valid;
    logic                        r_s2_restart;
    logic [2:0]                  r_s2_ref;
    logic [QW-1:0]               r_s2_si [NP];
    logic [QW-1:0]               r_s2_sq [NP];
    // stage 3: sums and first compare level
    logic                        r_s3_valid;
    logic                        r_s3_restart;
    logic [2:0]                  r_s3_ref;
    logic [SUMW-1:0]             r_s3_d   [NP/2];
    logic [2:0]                  r_s3_idx [NP/2];
    // stage 4: second compare level
    logic                        r_s4_valid;
    logic                        r_s4_restart;
    logic [2:0]                  r_s4_ref;
    logic [SUMW-1:0]             r_s4_d   [NP/4];
    logic [2:0]                  r_s4_idx [NP/4];
    // stage 5: decision and bit errors
    logic                        r_s5_valid;
    logic [2:0]                  r_s5_dec;
    logic [2:0]                  r_s5_ref;
    logic [1:0]                  r_s5_errs;
    logic                        r_s5_restart;
    // result register and counters
    logic                        r_out_valid;
    psk8_pkg::t_out_beat         r_out;
    logic [COUNT_WIDTH-1:0]      r_err;
    logic [COUNT_WIDTH-1:0]      r_bits;
    logic [COUNT_WIDTH-1:0]      n_err;
    logic [COUNT_WIDTH-1:0]      n_bits;
    logic [COUNT_WIDTH:0]        w_err_sum;
    logic [COUNT_WIDTH:0]        w_bits_sum;
    logic [2:0]                  w_s5_dec;
    logic [2:0]                  w_diff;

    // whole pipeline moves when the result slot is free or being taken
    assign w_adv   = !r_out_valid || i_pop;
    assign o_q_pop = w_adv && !i_q_empty;
    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

    // only the low sample bits count, sign taken from the top one
    assign w_ri = signed'(SAMPLE_WIDTH'(32'(unsigned'(i_task.rx_i))));
    assign w_rq = signed'(SAMPLE_WIDTH'(32'(unsigned'(i_task.rx_q))));

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= !i_q_empty;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // distance and min-search datapath
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_restart <= i_task.restart;
            r_s1_ref     <= i_task.ref_symbol;
            for (int k = 0; k < NP; k++) begin
                r_s1_di[k] <= coord(psk8_pkg::PT_I[k]) - DW'(w_ri);
                r_s1_dq[k] <= coord(psk8_pkg::PT_Q[k]) - DW'(w_rq);
            end

            r_s2_restart <= r_s1_restart;
            r_s2_ref     <= r_s1_ref;
            for (int k = 0; k < NP; k++) begin
                r_s2_si[k] <= QW'(r_s1_di[k] * r_s1_di[k]);
                r_s2_sq[k] <= QW'(r_s1_dq[k] * r_s1_dq[k]);
            end

            // right side wins only when strictly smaller: lowest index on ties
            r_s3_restart <= r_s2_restart;
            r_s3_ref     <= r_s2_ref;
            for (int k = 0; k < NP/2; k++) begin
                if ((SUMW'(r_s2_si[2*k+1]) + SUMW'(r_s2_sq[2*k+1]))
                        < (SUMW'(r_s2_si[2*k]) + SUMW'(r_s2_sq[2*k]))) begin
                    r_s3_d[k]   <= SUMW'(r_s2_si[2*k+1]) + SUMW'(r_s2_sq[2*k+1]);
                    r_s3_idx[k] <= 3'(2*k+1);
                end else begin
                    r_s3_d[k]   <= SUMW'(r_s2_si[2*k]) + SUMW'(r_s2_sq[2*k]);
                    r_s3_idx[k] <= 3'(2*k);
                end
            end

            r_s4_restart <= r_s3_restart;
            r_s4_ref     <= r_s3_ref;
            for (int k = 0; k < NP/4; k++) begin
                if (r_s3_d[2*k+1] < r_s3_d[2*k]) begin
                    r_s4_d[k]   <= r_s3_d[2*k+1];
                    r_s4_idx[k] <= r_s3_idx[2*k+1];
                end else begin
                    r_s4_d[k]   <= r_s3_d[2*k];
                    r_s4_idx[k] <= r_s3_idx[2*k];
                end
            end

            r_s5_restart <= r_s4_restart;
            r_s5_ref     <= r_s4_ref;
            r_s5_dec     <= r_s4_restart ? 3'd0 : w_s5_dec;
            r_s5_errs    <= r_s4_restart ? 2'd0
                          : 2'(w_diff[0]) + 2'(w_diff[1]) + 2'(w_diff[2]);
        end
    end

    // final compare and bit difference
    assign w_s5_dec = (r_s4_d[1] < r_s4_d[0]) ? r_s4_idx[1] : r_s4_idx[0];
    assign w_diff   = w_s5_dec ^ r_s4_ref;

    // saturating counter updates
    assign w_err_sum  = {1'b0, r_err} + (COUNT_WIDTH+1)'(r_s5_errs);
    assign w_bits_sum = {1'b0, r_bits} + (COUNT_WIDTH+1)'(psk8_pkg::BITS_PER_SYMBOL);
    always_comb begin
        if (r_s5_restart) begin
            n_err  = '0;
            n_bits = '0;
        end else begin
            n_err  = w_err_sum[COUNT_WIDTH] ? COUNT_MAX : w_err_sum[COUNT_WIDTH-1:0];
            n_bits = w_bits_sum[COUNT_WIDTH] ? COUNT_MAX : w_bits_sum[COUNT_WIDTH-1:0];
        end
    end

    // result slot valid and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_err       <= '0;
            r_bits      <= '0;
        end else if (w_adv) begin
            r_out_valid <= r_s5_valid;
            if (r_s5_valid) begin
                r_err  <= n_err;
                r_bits <= n_bits;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s5_valid) begin
            r_out.decided_symbol    <= r_s5_dec;
            r_out.reference_symbol  <= r_s5_ref;
            r_out.symbol_bit_errors <= r_s5_errs;
            r_out.total_bit_errors  <= 32'(n_err);
            r_out.total_bits        <= 32'(n_bits);
        end
    end

endmodule

@@ hw/rtl/psk8_slicer_prbs_error_counter.sv @@
// 8psk minimum-distance slicer with prbs bit-error counter, top level
// path: an accepted beat passes the queue, the back pipeline stages and the result register
// throughput: one beat per cycle while results are taken, through the 6-stage back pipeline and 4-entry queue
// the back pipeline stalls as a whole while a result waits; the queue keeps accepting until full
// reset: seed and prbs load 0x2AAAAAAA, both counters clear, queue and pipeline empty
`include "assert_macros.svh"

module psk8_slicer_prbs_error_counter #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psk8_pkg::PRBS_WIDTH-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  psk8_pkg::t_in_beat              i_data,
    output logic                            empty,
    input  logic                            pop,
    output psk8_pkg::t_out_beat             o_data
);

    logic            w_q_push;
    logic            w_q_full;
    logic            w_q_pop;
    logic            w_q_empty;
    psk8_pkg::t_task w_front_task;
    psk8_pkg::t_task w_back_task;

    assign full = w_q_full;

    // classify and generate reference
    psk8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data      (i_data),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_task      (w_front_task)
    );

    // decoupling queue
    psk8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_task  (w_front_task),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_task  (w_back_task),
        .o_empty (w_q_empty)
    );

    // slicing, compare and counting
    psk8_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_task    (w_back_task),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_data    (o_data)
    );

    // checks
    `ASSERT_IMPLIES(a_errs_match_symbols, i_clk, i_rst_n, !empty, ((o_data.decided_symbol ^ o_data.reference_symbol) == 3'd0) == (o_data.symbol_bit_errors == 2'd0))
    `ASSERT_IMPLIES(a_zero_bits_means_restart, i_clk, i_rst_n, !empty && (o_data.total_bits == 32'd0), (o_data.total_bit_errors == 32'd0) && (o_data.decided_symbol == 3'd0) && (o_data.reference_symbol == 3'd0))
    `ASSERT_NEXT(a_full_queue_holds, i_clk, i_rst_n, w_q_full && !w_q_pop, w_q_full)

endmodule

@@ bench/psk8_ber_check_pkg.sv @@
// scoreboard class and constellation constants for the 8psk slicer bench
package psk8_ber_check_pkg;

    import psk8_pkg::*;

    // Q2.13 at the default 16-bit sample width
    localparam int SYMBOL_ONE = 1 << (16 - 3);
    // one times 1/sqrt(2), rounded to nearest
    localparam longint unsigned DIAG_WIDE =
        (64'd8192 * 64'd3037000500 + 64'd2147483648) >> 32;
    localparam int SYMBOL_DIAG = int'(DIAG_WIDE);

    // point order of the block, gray coded
    localparam int POINT_I [8] = '{
        SYMBOL_ONE, SYMBOL_DIAG, -SYMBOL_DIAG, 0,
        SYMBOL_DIAG, 0, -SYMBOL_ONE, -SYMBOL_DIAG
    };
    localparam int POINT_Q [8] = '{
        0, SYMBOL_DIAG, SYMBOL_DIAG, SYMBOL_ONE,
        -SYMBOL_DIAG, -SYMBOL_ONE, 0, -SYMBOL_DIAG
    };

    localparam logic [30:0] SEED_AT_RESET = 31'h2AAA_AAAA;

    class ber_scoreboard;
        logic [30:0] seed_reg;
        logic [30:0] lfsr;
        logic [31:0] errors_total;
        logic [31:0] bits_total;
        t_out_beat   expected_q[$];
        int unsigned fail_count;

        function new();
            seed_reg     = SEED_AT_RESET;
            lfsr         = SEED_AT_RESET;
            errors_total = '0;
            bits_total   = '0;
            fail_count   = 0;
        endfunction

        function void write_seed(logic [30:0] value);
            seed_reg = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // one prbs shift: bit 30 leaves, bit 30 xor bit 2 enters
        function logic shift_lfsr();
            logic out_bit;
            out_bit = lfsr[30];
            lfsr    = {lfsr[29:0], out_bit ^ lfsr[2]};
            return out_bit;
        endfunction

        function logic [31:0] sat_add(logic [31:0] acc, int unsigned amount);
            logic [32:0] sum;
            sum = {1'b0, acc} + 33'(amount);
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        // predict the result beat of one accepted input beat
        function void note_input(t_in_beat beat);
            t_out_beat   want;
            longint      ri, rq, di, dq, dist_sq, best;
            logic [2:0]  diff;
            int          k;
            want = '0;
            best = 0;
            if (beat.kind == KIND_RESTART) begin
                lfsr         = seed_reg;
                errors_total = '0;
                bits_total   = '0;
            end else begin
                ri = longint'($signed(beat.rx_i));
                rq = longint'($signed(beat.rx_q));
                want.reference_symbol[2] = shift_lfsr();
                want.reference_symbol[1] = shift_lfsr();
                want.reference_symbol[0] = shift_lfsr();
                // nearest point, lowest index wins a tie
                for (k = 0; k < 8; k++) begin
                    di      = longint'(POINT_I[k]) - ri;
                    dq      = longint'(POINT_Q[k]) - rq;
                    dist_sq = di * di + dq * dq;
                    if (k == 0 || dist_sq < best) begin
                        best = dist_sq;
                        want.decided_symbol = 3'(k);
                    end
                end
                diff = want.decided_symbol ^ want.reference_symbol;
                want.symbol_bit_errors = 2'(diff[0]) + 2'(diff[1]) + 2'(diff[2]);
                errors_total = sat_add(errors_total, want.symbol_bit_errors);
                bits_total   = sat_add(bits_total, 3);
            end
            want.total_bit_errors = errors_total;
            want.total_bits       = bits_total;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s expected %0d got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_result(t_out_beat got);
            t_out_beat want;
            if (expected_q.size() == 0) begin
                $error("result beat with no prediction waiting");
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("decided_symbol", 32'(want.decided_symbol), 32'(got.decided_symbol));
            compare_field("reference_symbol", 32'(want.reference_symbol),
                          32'(got.reference_symbol));
            compare_field("symbol_bit_errors", 32'(want.symbol_bit_errors),
                          32'(got.symbol_bit_errors));
            compare_field("total_bit_errors", want.total_bit_errors, got.total_bit_errors);
            compare_field("total_bits", want.total_bits, got.total_bits);
        endfunction
    endclass

endpackage

@@ bench/psk8_slicer_prbs_error_counter_tb.sv @@
// testbench top of the 8psk slicer with prbs bit-error counter
module psk8_slicer_prbs_error_counter_tb;

    import psk8_pkg::*;
    import psk8_ber_check_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [PRBS_WIDTH-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    t_in_beat              i_data;
    logic                  empty;
    logic                  pop;
    t_out_beat             o_data;

    logic                  steady;
    int                    quiet_cycles;
    ber_scoreboard         sb = new();

    psk8_slicer_prbs_error_counter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // monitor: predict on input beats, check result beats, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_seed(i_cfg_data);
            end
            if (push && !full) begin
                sb.note_input(i_data);
            end
            if (pop && !empty) begin
                sb.check_result(o_data);
            end
            if ((i_cfg_valid && o_cfg_ready) || (push && !full) || (pop && !empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // result side: random pop stalls, none once steady
    initial begin
        pop <= 1'b0;
        forever begin
            if (!steady && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic t_in_beat sample_beat(int vi, int vq);
        t_in_beat beat;
        if (vi > 32767) vi = 32767;
        if (vi < -32768) vi = -32768;
        if (vq > 32767) vq = 32767;
        if (vq < -32768) vq = -32768;
        beat.kind = KIND_SAMPLE;
        beat.rx_i = 16'(vi);
        beat.rx_q = 16'(vq);
        return beat;
    endfunction

    // restart beat, sample fields carry junk that must be ignored
    function automatic t_in_beat restart_beat();
        t_in_beat    beat;
        logic [31:0] r;
        r = $urandom;
        beat.kind = KIND_RESTART;
        beat.rx_i = r[15:0];
        beat.rx_q = r[31:16];
        return beat;
    endfunction

    function automatic int jitter(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // mostly noisy constellation points, some raw words and restarts
    function automatic t_in_beat random_beat();
        t_in_beat    beat;
        logic [31:0] r;
        int          pick, spread, idx;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        if (pick < 3) begin
            return restart_beat();
        end
        if (pick < 25) begin
            beat.kind = KIND_SAMPLE;
            beat.rx_i = r[15:0];
            beat.rx_q = r[31:16];
            return beat;
        end
        spread = (pick < 45) ? 4000 : (pick < 75) ? 1500 : 300;
        idx    = $urandom_range(0, 7);
        return sample_beat(POINT_I[idx] + jitter(spread), POINT_Q[idx] + jitter(spread));
    endfunction

    function automatic logic [30:0] pick_seed();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: begin
                return 31'h7FFF_FFFF;
            end
            1: begin
                return 31'd1;
            end
            default: begin
                return r[30:0];
            end
        endcase
    endfunction

    // one input beat, then maybe a gap
    task automatic send_beat(input t_in_beat beat);
        push   <= 1'b1;
        i_data <= beat;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (!steady && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic write_seed(input logic [30:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every predicted beat to come back
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int k;
        int phase;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        steady      <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset seed: every point exactly, the origin where the axis points tie, the corners
        for (k = 0; k < 8; k++) begin
            send_beat(sample_beat(POINT_I[k], POINT_Q[k]));
        end
        send_beat(sample_beat(0, 0));
        send_beat(sample_beat(32767, 32767));
        send_beat(sample_beat(-32768, -32768));
        send_beat(sample_beat(32767, -32768));
        send_beat(sample_beat(-32768, 32767));
        send_beat(restart_beat());
        send_beat(sample_beat(POINT_I[3], POINT_Q[3]));

        // all-zero seed keeps the prbs stuck at zero
        drain();
        write_seed(31'd0);
        send_beat(restart_beat());
        repeat (3) send_beat(random_beat());

        // all-ones seed
        drain();
        write_seed(31'h7FFF_FFFF);
        send_beat(restart_beat());
        repeat (3) send_beat(random_beat());

        // random phases, the last one without idling
        for (phase = 0; phase < 6; phase++) begin
            drain();
            write_seed(pick_seed());
            steady <= (phase == 5);
            if ($urandom_range(0, 3) != 0) begin
                send_beat(restart_beat());
            end
            repeat (215) send_beat(random_beat());
        end

        drain();
        repeat (12) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ psk8_slicer_prbs_error_counter.f @@
+incdir+hw/rtl
hw/rtl/psk8_pkg.sv
hw/rtl/psk8_front.sv
hw/rtl/psk8_queue.sv
hw/rtl/psk8_back.sv
hw/rtl/psk8_slicer_prbs_error_counter.sv
bench/psk8_ber_check_pkg.sv
bench/psk8_slicer_prbs_error_counter_tb.sv
